// File: design/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
// no dependencies; imported by ffha_dp, ffha_ctrl and the top level
package ffha_pkg;

    // fixed field widths
    localparam int ADDR_W = 17;              // byte address with one carry bit
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 15;
    localparam int KIND_W = 2;
    localparam int BADDR_W = 16;

    // arena geometry
    localparam logic [ADDR_W-1:0] ARENA_BASE = 17'h08000;
    localparam int ARENA_END_DEF = 32'hFF00;
    localparam int MIN_SPLIT = 1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

    // header byte masks
    localparam logic [BYTE_W-1:0] LINK_HI_MASK = 8'h7F;

    typedef enum logic [2:0] {
        A_BLK,
        A_BLK1,
        A_NXT,
        A_NXT1,
        A_REST,
        A_REST1,
        A_FREE
    } addr_sel_t;

    typedef enum logic [2:0] {
        W_TGT_LO,
        W_TGT_HI,
        W_NXT_LO,
        W_NXT_HI,
        W_CLR_USED
    } wdata_sel_t;

    typedef enum logic [1:0] {
        B_HOLD,
        B_BASE,
        B_LINK,
        B_NEXT
    } blk_op_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_OK,
        RES_ALLOC
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic       take;       // capture request fields
        blk_op_t    blk_op;
        logic       nxt_load;   // next pointer <- decoded link
        logic       rd_en;
        logic       wr_en;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       lat_lo;
        logic       lat_hi;
        logic       reinit;
        logic       out_load;
        res_t       res;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic blk_end;      // blk + 1 at or beyond arena end
        logic nxt_end;      // next + 1 at or beyond arena end
        logic link_le_blk;  // decoded link does not advance past blk
        logic link_le_nxt;  // decoded link does not advance past next
        logic hdr_used;
        logic fits;
        logic split;
        logic free_ok;      // free address inside the arena
    } status_t;

endpackage

// File: design/ffha_dp.sv
// datapath of the first-fit heap allocator: arena memory, pointers, result registers
// depends on ffha_pkg; driven by ffha_ctrl through cmd_t
module ffha_dp #(
    parameter int ARENA_END = ffha_pkg::ARENA_END_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffha_pkg::cmd_t                      cmd,
    output ffha_pkg::status_t                   status,
    input  logic [ffha_pkg::SIZE_W-1:0]         alloc_size,
    input  logic [ffha_pkg::BADDR_W-1:0]        free_address,
    output logic [ffha_pkg::BADDR_W-1:0]        block_address,
    output logic                                ok
);
    import ffha_pkg::*;

    localparam int AREA = ARENA_END - 32'(ARENA_BASE);
    localparam int IDX_W = $clog2(AREA);
    localparam logic [ADDR_W-1:0] END_A = ADDR_W'(ARENA_END);
    localparam logic [ADDR_W-1:0] BASE_1 = ARENA_BASE + 17'd1;
    localparam logic [ADDR_W-1:0] SPLIT_PAD = ADDR_W'(4 + MIN_SPLIT);

    typedef enum logic [1:0] {
        R_ZERO,
        R_H0,
        R_H1,
        R_MEM
    } rsel_t;

    logic [BYTE_W-1:0]  mem [AREA];
    logic [BYTE_W-1:0]  mem_q;
    rsel_t              rsel_reg, rsel_next;
    logic [BYTE_W-1:0]  hdr0_reg, hdr1_reg;   // header bytes of the first block

    logic [SIZE_W-1:0]  size_reg;
    logic [BADDR_W-1:0] faddr_reg;
    logic [ADDR_W-1:0]  blk_reg, nxt_reg;
    logic [BYTE_W-1:0]  lo_reg, hi_reg;
    logic [BADDR_W-1:0] block_address_reg;
    logic               ok_reg;

    logic [ADDR_W-1:0]  link, span, size_x, rest, target, faddr_x, addr, off;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [BYTE_W-1:0]  rdata, wdata;

    always_comb
    begin
        link    = {2'b01, hi_reg[6:0], lo_reg};
        span    = nxt_reg - blk_reg;
        size_x  = {{(ADDR_W-SIZE_W){1'b0}}, size_reg};
        rest    = blk_reg + size_x + 17'd2;
        faddr_x = {1'b0, faddr_reg};

        status.blk_end     = (blk_reg + 17'd1) >= END_A;
        status.nxt_end     = (nxt_reg + 17'd1) >= END_A;
        status.link_le_blk = link <= blk_reg;
        status.link_le_nxt = link <= nxt_reg;
        status.hdr_used    = hi_reg[7];
        status.fits        = (size_x + 17'd2) < span;
        status.split       = (size_x + SPLIT_PAD) < span;
        status.free_ok     = (faddr_x >= BASE_1) && (faddr_x <= END_A);

        target = status.split ? rest : nxt_reg;
    end

    // address select and arena range check
    always_comb
    begin
        case (cmd.addr_sel)
            A_BLK:   addr = blk_reg;
            A_BLK1:  addr = blk_reg + 17'd1;
            A_NXT:   addr = nxt_reg;
            A_NXT1:  addr = nxt_reg + 17'd1;
            A_REST:  addr = rest;
            A_REST1: addr = rest + 17'd1;
            A_FREE:  addr = faddr_x - 17'd1;
            default: addr = blk_reg;
        endcase
        in_range = (addr >= ARENA_BASE) && (addr < END_A);
        off      = addr - ARENA_BASE;
        idx      = off[IDX_W-1:0];

        if (!in_range)
            rsel_next = R_ZERO;
        else if (addr == ARENA_BASE)
            rsel_next = R_H0;
        else if (addr == BASE_1)
            rsel_next = R_H1;
        else
            rsel_next = R_MEM;
    end

    always_comb
    begin
        case (rsel_reg)
            R_ZERO:  rdata = '0;
            R_H0:    rdata = hdr0_reg;
            R_H1:    rdata = hdr1_reg;
            R_MEM:   rdata = mem_q;
            default: rdata = '0;
        endcase

        case (cmd.wdata_sel)
            W_TGT_LO:   wdata = target[7:0];
            W_TGT_HI:   wdata = {status.fits, target[14:8]};
            W_NXT_LO:   wdata = nxt_reg[7:0];
            W_NXT_HI:   wdata = {1'b0, nxt_reg[14:8]};
            W_CLR_USED: wdata = rdata & LINK_HI_MASK;
            default:    wdata = '0;
        endcase
    end

    // arena memory, one port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && rsel_next == R_MEM)
            mem[idx] <= wdata;
        if (cmd.rd_en)
            mem_q <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsel_reg <= R_ZERO;
            hdr0_reg <= END_A[7:0];
            hdr1_reg <= {1'b0, END_A[14:8]};
        end
        else
        begin
            if (cmd.rd_en)
                rsel_reg <= rsel_next;
            if (cmd.reinit)
            begin
                hdr0_reg <= END_A[7:0];
                hdr1_reg <= {1'b0, END_A[14:8]};
            end
            else if (cmd.wr_en && rsel_next == R_H0)
                hdr0_reg <= wdata;
            else if (cmd.wr_en && rsel_next == R_H1)
                hdr1_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            size_reg  <= alloc_size;
            faddr_reg <= free_address;
        end
        case (cmd.blk_op)
            B_BASE:  blk_reg <= ARENA_BASE;
            B_LINK:  blk_reg <= link;
            B_NEXT:  blk_reg <= nxt_reg;
            default: blk_reg <= blk_reg;
        endcase
        if (cmd.nxt_load)
            nxt_reg <= link;
        if (cmd.lat_lo)
            lo_reg <= rdata;
        if (cmd.lat_hi)
            hi_reg <= rdata;
        if (cmd.out_load)
        begin
            block_address_reg <= (cmd.res == RES_ALLOC) ? blk_reg[15:0] + 16'd2 : '0;
            ok_reg            <= (cmd.res != RES_FAIL);
        end
    end

    assign block_address = block_address_reg;
    assign ok            = ok_reg;

endmodule

// File: design/ffha_ctrl.sv
// controller of the first-fit heap allocator: request sequencing and handshakes
// depends on ffha_pkg; commands ffha_dp through cmd_t
module ffha_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ffha_pkg::KIND_W-1:0]  kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  ffha_pkg::status_t            status,
    output ffha_pkg::cmd_t               cmd
);
    import ffha_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WALK,
        S_BHI,
        S_BLAT,
        S_BEVAL,
        S_MCHK,
        S_MHI,
        S_MLAT,
        S_MEVAL,
        S_W0,
        S_W1,
        S_W2,
        S_W3,
        S_FRD,
        S_FWR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    res_t   res_reg, res_next;

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res        = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    cmd.blk_op = B_BASE;
                    state_next = S_DONE;
                    res_next   = RES_FAIL;
                    case (kind)
                        KIND_ALLOC:  state_next = S_WALK;
                        KIND_FREE:   state_next = S_FRD;
                        KIND_REINIT:
                        begin
                            cmd.reinit = 1'b1;
                            res_next   = RES_OK;
                        end
                        default:     res_next = RES_FAIL;
                    endcase
                end
            end
            // header of the current block
            S_WALK:
            begin
                if (status.blk_end)
                begin
                    res_next   = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = A_BLK;
                    state_next   = S_BHI;
                end
            end
            S_BHI:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_BLK1;
                cmd.lat_lo   = 1'b1;
                state_next   = S_BLAT;
            end
            S_BLAT:
            begin
                cmd.lat_hi = 1'b1;
                state_next = S_BEVAL;
            end
            S_BEVAL:
            begin
                if (status.link_le_blk)
                begin
                    res_next   = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.nxt_load = 1'b1;
                    if (status.hdr_used)
                    begin
                        cmd.blk_op = B_LINK;
                        state_next = S_WALK;
                    end
                    else
                        state_next = S_MCHK;
                end
            end
            // merge the run of free neighbors
            S_MCHK:
            begin
                if (status.nxt_end)
                    state_next = S_W0;
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = A_NXT;
                    state_next   = S_MHI;
                end
            end
            S_MHI:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = A_NXT1;
                cmd.lat_lo   = 1'b1;
                state_next   = S_MLAT;
            end
            S_MLAT:
            begin
                cmd.lat_hi = 1'b1;
                state_next = S_MEVAL;
            end
            S_MEVAL:
            begin
                if (status.hdr_used)
                    state_next = S_W0;
                else if (status.link_le_nxt)
                begin
                    res_next   = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.nxt_load = 1'b1;
                    state_next   = S_MCHK;
                end
            end
            // header write back; split when there is room, walk on when the request does not fit
            S_W0:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_BLK;
                cmd.wdata_sel = W_TGT_LO;
                state_next    = S_W1;
            end
            S_W1:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_BLK1;
                cmd.wdata_sel = W_TGT_HI;
                if (!status.fits)
                begin
                    cmd.blk_op = B_NEXT;
                    state_next = S_WALK;
                end
                else if (status.split)
                    state_next = S_W2;
                else
                begin
                    res_next   = RES_ALLOC;
                    state_next = S_DONE;
                end
            end
            S_W2:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_REST;
                cmd.wdata_sel = W_NXT_LO;
                state_next    = S_W3;
            end
            S_W3:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_REST1;
                cmd.wdata_sel = W_NXT_HI;
                res_next      = RES_ALLOC;
                state_next    = S_DONE;
            end
            // free: read-modify-write of the header high byte
            S_FRD:
            begin
                if (!status.free_ok)
                begin
                    res_next   = RES_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = A_FREE;
                    state_next   = S_FWR;
                end
            end
            S_FWR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.addr_sel  = A_FREE;
                cmd.wdata_sel = W_CLR_USED;
                res_next      = RES_OK;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            res_reg       <= RES_FAIL;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: design/first_fit_heap_allocator_top.sv
// top level of the first-fit heap allocator
// depends on ffha_pkg, ffha_ctrl and ffha_dp
//
// usage
//   requests enter on the in channel (kind, alloc_size, free_address) and
//   every request gives exactly one result beat on the out channel
//   (block_address, ok). one request is in work at a time; in_ready is high
//   only while the sequencer is idle.
//   allocate walks the block headers from the arena base. each header read
//   uses the single arena memory port in steps (two byte reads, latch,
//   evaluate); a free block then reads the headers after it the same way
//   until a used block or the chain end is reached. a header write back
//   writes two bytes and a split two more, between the accept and result
//   steps. free steps through accept, range check and read, write and
//   result; a free outside the arena through accept, range check and result,
//   reinit and an unknown kind through accept and result.
//   the result sits in an output register: a new request is taken while it
//   waits, but the following result holds in the sequencer until the
//   receiver takes the earlier beat.
//   reset clears the control state and restores the first header so that
//   the arena is one free block; all other arena bytes are undefined until
//   written and need no clearing pass.
module first_fit_heap_allocator_top #(
    parameter int ARENA_END = ffha_pkg::ARENA_END_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ffha_pkg::KIND_W-1:0]    kind,
    input  logic [ffha_pkg::SIZE_W-1:0]    alloc_size,
    input  logic [ffha_pkg::BADDR_W-1:0]   free_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ffha_pkg::BADDR_W-1:0]   block_address,
    output logic                           ok
);
    import ffha_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: walk, merge, split, free and the handshakes
    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arena memory, pointer registers and result beat
    ffha_dp #(
        .ARENA_END (ARENA_END)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .alloc_size    (alloc_size),
        .free_address  (free_address),
        .block_address (block_address),
        .ok            (ok)
    );

endmodule

// File: design/ffha_checker.sv
// port-level checks for the first-fit heap allocator, bound to the top level
// no package dependency; watches first_fit_heap_allocator_top ports only
module ffha_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] block_address,
    input  logic        ok
);
    logic [1:0] pend_reg, pend_next;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_beat && !out_beat)
            pend_next = pend_reg + 2'd1;
        else if (out_beat && !in_beat)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_address) && $stable(ok))
        else $error("result beat changed while stalled");

    // a returned block lies in the arena and reports success
    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_address != 16'd0 |-> ok && block_address[15])
        else $error("block address without success or outside arena");

    // at most one request in work and one result waiting
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

    // no result beat without an accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat without request");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);
